// ===== rtl/core/bms_temperature_reply_checker_unit_defines.svh =====
// assertion macros for the temperature reply checker
`ifndef BMS_TEMPERATURE_REPLY_CHECKER_UNIT_DEFINES_SVH
`define BMS_TEMPERATURE_REPLY_CHECKER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// checked only while out of reset
`define BMSTRC_ASSERT_RUN(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("bmstrc assertion failed");
// checked at every edge, reset included
`define BMSTRC_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge aclk) prop) \
        else $error("bmstrc assertion failed");
`else
`define BMSTRC_ASSERT_RUN(label, prop)
`define BMSTRC_ASSERT_ALWAYS(label, prop)
`endif

`endif

// ===== rtl/core/bmstrc_pkg.sv =====
// ----------------------------------------------------------------------------
// bmstrc_pkg
// Shared types, constants and the CRC-16/MODBUS byte update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bmstrc_pkg;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [7:0]  ERR_MARK = 8'h00;

    // reply status codes
    localparam logic [1:0] STATUS_DATA_OK  = 2'd0;
    localparam logic [1:0] STATUS_DATA_BAD = 2'd1;
    localparam logic [1:0] STATUS_ERR_OK   = 2'd2;
    localparam logic [1:0] STATUS_ERR_BAD  = 2'd3;

    // byte positions inside a reply
    localparam logic [3:0] POS_KIND     = 4'd1;
    localparam logic [3:0] POS_LENGTH   = 4'd2;
    localparam logic [3:0] POS_ERR_CODE = 4'd3;
    localparam logic [3:0] POS_ERR_CRCL = 4'd4;
    localparam logic [3:0] POS_ERR_LAST = 4'd5;
    localparam logic [3:0] POS_T0_LOW   = 4'd3;
    localparam logic [3:0] POS_T0_HIGH  = 4'd4;
    localparam logic [3:0] POS_T1_LOW   = 4'd5;
    localparam logic [3:0] POS_T1_HIGH  = 4'd6;
    localparam logic [3:0] POS_T2_LOW   = 4'd7;
    localparam logic [3:0] POS_T2_HIGH  = 4'd8;
    localparam logic [3:0] POS_DAT_CRCL = 4'd9;
    localparam logic [3:0] POS_DAT_LAST = 4'd10;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  error_code;
        logic [7:0]  payload_length;
        logic [15:0] internal_temp;
        logic [15:0] external_temp_one;
        logic [15:0] external_temp_two;
    } result_t;

    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bms_temperature_reply_checker_unit.sv =====
// Temperature reply checker: takes reply bytes one word per cycle, runs a
// CRC-16/MODBUS over them and gives one result word per finished frame
// (6-byte error reply or 11-byte data reply). A new byte is taken in every
// cycle while the result side keeps up; a byte leaves the input register only
// when the result register is empty or being read, so a result left waiting
// holds the input. A byte moves through an input register and the result
// register before its frame's result shows as valid. The CRC update of one
// byte is done combinationally between those registers.
// ----------------------------------------------------------------------------
// bms_temperature_reply_checker_unit
// Top level: input register, frame core and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "bms_temperature_reply_checker_unit_defines.svh"

module bms_temperature_reply_checker_unit
    import bmstrc_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [7:0]         s_rx_byte,
    input  wire logic               s_frame_start,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [1:0]              m_status,
    output logic [7:0]              m_error_code,
    output logic [7:0]              m_payload_length,
    output logic signed [15:0]      m_internal_temp,
    output logic signed [15:0]      m_external_temp_one,
    output logic signed [15:0]      m_external_temp_two
);

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_start_reg;
    logic        out_valid_reg, out_valid_next;
    result_t     out_reg;
    logic        advance;
    logic        res_fire;
    result_t     res;

    // byte leaves the input register once the result register has room
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg  <= s_rx_byte;
            in_start_reg <= s_frame_start;
        end
    end

    bmstrc_frame_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (advance),
        .rx_byte     (in_byte_reg),
        .frame_start (in_start_reg),
        .res_fire    (res_fire),
        .res         (res)
    );

    always_comb begin
        if (res_fire) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_fire) begin
            out_reg <= res;
        end
    end

    assign m_valid             = out_valid_reg;
    assign m_status            = out_reg.status;
    assign m_error_code        = out_reg.error_code;
    assign m_payload_length    = out_reg.payload_length;
    assign m_internal_temp     = $signed(out_reg.internal_temp);
    assign m_external_temp_one = $signed(out_reg.external_temp_one);
    assign m_external_temp_two = $signed(out_reg.external_temp_two);

    `BMSTRC_ASSERT_RUN(a_fire_shows_result, res_fire |=> m_valid)
    `BMSTRC_ASSERT_RUN(a_stalled_word_kept, in_valid_reg && !advance |=> in_valid_reg)
    `BMSTRC_ASSERT_ALWAYS(a_reset_empties, !aresetn |=> !m_valid && s_ready)

endmodule

`default_nettype wire

// ===== rtl/core/bmstrc_frame_core.sv =====
// ----------------------------------------------------------------------------
// bmstrc_frame_core
// Frame tracking, running CRC and field capture; one byte per step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bmstrc_frame_core
    import bmstrc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        step,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        frame_start,
    output logic             res_fire,
    output result_t          res
);

    logic [3:0]  pos_reg, pos_next;
    logic        in_frame_reg, in_frame_next;
    logic [15:0] crc_reg, crc_next;
    logic        err_reg, err_next;
    logic [7:0]  len_code_reg, len_code_next;
    logic [15:0] t0_reg, t0_next;
    logic [15:0] t1_reg, t1_next;
    logic [15:0] t2_reg, t2_next;
    logic [7:0]  crcl_reg, crcl_next;

    logic        active;
    logic [3:0]  pos;
    logic [15:0] crc_base;
    logic [15:0] crc_upd;
    logic        err;
    logic        covered;
    logic        done;
    logic        crc_match;

    always_comb begin
        active    = frame_start || in_frame_reg;
        pos       = frame_start ? 4'd0 : pos_reg;
        crc_base  = frame_start ? CRC_INIT : crc_reg;
        err       = frame_start ? 1'b0 : err_reg;
        if (pos == POS_KIND) begin
            err = (rx_byte == ERR_MARK);
        end
        crc_upd   = crc_step(crc_base, rx_byte);
        covered   = err ? (pos <= POS_ERR_CODE) : (pos <= POS_T2_HIGH);
        done      = active && (err ? (pos == POS_ERR_LAST) : (pos == POS_DAT_LAST));
        crc_match = (crc_base == {rx_byte, crcl_reg});

        pos_next      = pos_reg;
        in_frame_next = in_frame_reg;
        crc_next      = crc_reg;
        err_next      = err_reg;
        len_code_next = len_code_reg;
        t0_next       = t0_reg;
        t1_next       = t1_reg;
        t2_next       = t2_reg;
        crcl_next     = crcl_reg;

        if (active) begin
            crc_next      = covered ? crc_upd : crc_base;
            err_next      = err;
            in_frame_next = !done;
            pos_next      = done ? 4'd0 : pos + 4'd1;
            if (err) begin
                if (pos == POS_ERR_CODE) begin
                    len_code_next = rx_byte;
                end else if (pos == POS_ERR_CRCL) begin
                    crcl_next = rx_byte;
                end
            end else begin
                case (pos)
                    POS_LENGTH:   len_code_next = rx_byte;
                    POS_T0_LOW:   t0_next = {8'h00, rx_byte};
                    POS_T0_HIGH:  t0_next = {rx_byte, t0_reg[7:0]};
                    POS_T1_LOW:   t1_next = {8'h00, rx_byte};
                    POS_T1_HIGH:  t1_next = {rx_byte, t1_reg[7:0]};
                    POS_T2_LOW:   t2_next = {8'h00, rx_byte};
                    POS_T2_HIGH:  t2_next = {rx_byte, t2_reg[7:0]};
                    POS_DAT_CRCL: crcl_next = rx_byte;
                    default:      ;
                endcase
            end
        end
    end

    always_comb begin
        res_fire = step && done;
        if (err) begin
            res.status            = crc_match ? STATUS_ERR_OK : STATUS_ERR_BAD;
            res.error_code        = len_code_reg;
            res.payload_length    = 8'h00;
            res.internal_temp     = 16'h0000;
            res.external_temp_one = 16'h0000;
            res.external_temp_two = 16'h0000;
        end else begin
            res.status            = crc_match ? STATUS_DATA_OK : STATUS_DATA_BAD;
            res.error_code        = 8'h00;
            res.payload_length    = len_code_reg;
            res.internal_temp     = t0_reg;
            res.external_temp_one = t1_reg;
            res.external_temp_two = t2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= 4'd0;
            in_frame_reg <= 1'b0;
            crc_reg      <= CRC_INIT;
            err_reg      <= 1'b0;
        end else if (step) begin
            pos_reg      <= pos_next;
            in_frame_reg <= in_frame_next;
            crc_reg      <= crc_next;
            err_reg      <= err_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            len_code_reg <= len_code_next;
            t0_reg       <= t0_next;
            t1_reg       <= t1_next;
            t2_reg       <= t2_next;
            crcl_reg     <= crcl_next;
        end
    end

endmodule

`default_nettype wire

// ===== tb/tb_bms_temperature_reply_checker_unit.sv =====
// ----------------------------------------------------------------------------
// tb_bms_temperature_reply_checker_unit
// Feeds temperature reply frames byte by byte (error replies, data replies,
// cut-off frames and stray bytes) and checks every result word against a
// behavioral parser with its own CRC-16/MODBUS or a typed expected word, under
// random stalls on both channels, one long output hold-off and one drain pause.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_bms_temperature_reply_checker_unit;
    import bmstrc_pkg::*;

    localparam logic [7:0]  NODE_ADDR      = 8'hAA;
    localparam logic [7:0]  CMD_READ_TEMPS = 8'h1B;
    localparam logic [15:0] TEMP_ABSENT    = 16'h8000;
    localparam logic [15:0] TEMP_MAX       = 16'h7FFF;
    localparam int TOTAL_ITEMS   = 950;
    localparam int TAIL_ITEMS    = 120;
    localparam int HOLD_AT       = 250;
    localparam int LONG_HOLD     = 150;
    localparam int PAUSE_AT      = 600;
    localparam int DRAIN_CYCLES  = 20;
    localparam int STALL_LIMIT   = 1000;
    localparam int DIRECTED_ROWS = 7;

    typedef struct packed {
        logic        stray;
        logic        err_kind;
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [7:0]  b2;
        logic [7:0]  b3;
        logic [15:0] t0;
        logic [15:0] t1;
        logic [15:0] t2;
        logic [15:0] crc_flip;
        logic [3:0]  cut;
        logic        typed;
        result_t     want;
    } reply_row_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [7:0]         s_rx_byte;
    logic               s_frame_start;
    logic               m_valid;
    logic               m_ready;
    logic [1:0]         m_status;
    logic [7:0]         m_error_code;
    logic [7:0]         m_payload_length;
    logic signed [15:0] m_internal_temp;
    logic signed [15:0] m_external_temp_one;
    logic signed [15:0] m_external_temp_two;

    // parser state mirrored in the testbench
    logic [3:0]  frame_pos;
    logic        frame_open;
    logic [15:0] crc_acc;
    logic        err_reply;
    logic [7:0]  held_len_code;
    logic [15:0] held_temp [3];
    logic [7:0]  held_crc_lo;

    result_t     expected_replies [$];
    logic [7:0]  reply_bytes [$];
    reply_row_t  directed_rows [DIRECTED_ROWS];
    int          items_sent;
    int          mismatches;
    int          stall_cycles;
    int          tx_calm;
    int          rx_calm;
    bit          steady_tail;
    bit          long_hold_done;

    bms_temperature_reply_checker_unit u_top (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_rx_byte           (s_rx_byte),
        .s_frame_start       (s_frame_start),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_status            (m_status),
        .m_error_code        (m_error_code),
        .m_payload_length    (m_payload_length),
        .m_internal_temp     (m_internal_temp),
        .m_external_temp_one (m_external_temp_one),
        .m_external_temp_two (m_external_temp_two)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] acc;
        acc = crc ^ {8'h00, b};
        repeat (8) begin
            acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
        end
        return acc;
    endfunction

    // advances the mirrored parser by one word, returns 1 when a frame closes
    function automatic bit reply_parse_byte(input logic [7:0] b, input logic st,
                                            output result_t r);
        logic [3:0]  pos;
        logic [3:0]  rel;
        logic [15:0] rx_crc;
        r = '0;
        if (st) begin
            frame_open = 1'b1;
            frame_pos  = 4'd0;
            crc_acc    = CRC_INIT;
            err_reply  = 1'b0;
        end else if (!frame_open) begin
            return 1'b0;
        end
        pos = frame_pos;
        if (pos == POS_KIND) err_reply = (b == ERR_MARK);
        if (err_reply) begin
            if (pos <= POS_ERR_CODE) crc_acc = crc16_byte(crc_acc, b);
            if (pos == POS_ERR_CODE) begin
                held_len_code = b;
            end else if (pos == POS_ERR_CRCL) begin
                held_crc_lo = b;
            end else if (pos == POS_ERR_LAST) begin
                rx_crc       = {b, held_crc_lo};
                r.status     = (crc_acc == rx_crc) ? STATUS_ERR_OK : STATUS_ERR_BAD;
                r.error_code = held_len_code;
                frame_open   = 1'b0;
                frame_pos    = 4'd0;
                return 1'b1;
            end
        end else begin
            if (pos <= POS_T2_HIGH) crc_acc = crc16_byte(crc_acc, b);
            if (pos == POS_LENGTH) begin
                held_len_code = b;
            end else if (pos >= POS_T0_LOW && pos <= POS_T2_HIGH) begin
                rel = pos - POS_T0_LOW;
                // even offset from the first temperature byte is the low byte
                if (!rel[0]) held_temp[rel[2:1]] = {8'h00, b};
                else held_temp[rel[2:1]][15:8] = b;
            end else if (pos == POS_DAT_CRCL) begin
                held_crc_lo = b;
            end else if (pos == POS_DAT_LAST) begin
                rx_crc              = {b, held_crc_lo};
                r.status            = (crc_acc == rx_crc) ? STATUS_DATA_OK : STATUS_DATA_BAD;
                r.payload_length    = held_len_code;
                r.internal_temp     = held_temp[0];
                r.external_temp_one = held_temp[1];
                r.external_temp_two = held_temp[2];
                frame_open          = 1'b0;
                frame_pos           = 4'd0;
                return 1'b1;
            end
        end
        frame_pos = pos + 4'd1;
        return 1'b0;
    endfunction

    function automatic void build_reply(input logic err_kind, input logic [7:0] b0,
                                        input logic [7:0] b1, input logic [7:0] b2,
                                        input logic [7:0] b3, input logic [15:0] t0,
                                        input logic [15:0] t1, input logic [15:0] t2,
                                        input logic [15:0] crc_flip);
        logic [15:0] crc;
        crc = CRC_INIT;
        if (err_kind) begin
            reply_bytes = '{b0, ERR_MARK, b2, b3};
        end else begin
            reply_bytes = '{b0, b1, b2, t0[7:0], t0[15:8], t1[7:0], t1[15:8],
                            t2[7:0], t2[15:8]};
        end
        foreach (reply_bytes[i]) crc = crc16_byte(crc, reply_bytes[i]);
        crc = crc ^ crc_flip;
        reply_bytes.push_back(crc[7:0]);
        reply_bytes.push_back(crc[15:8]);
    endfunction

    function automatic logic [15:0] pick_temp();
        case ($urandom_range(0, 7))
            0: return TEMP_ABSENT;
            1: return TEMP_MAX;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic st, input bit counted,
                             input bit use_typed, input result_t typed_want);
        result_t predicted;
        bit      has_reply;
        s_valid       <= 1'b1;
        s_rx_byte     <= b;
        s_frame_start <= st;
        do @(posedge aclk); while (s_ready !== 1'b1);
        has_reply = reply_parse_byte(b, st, predicted);
        if (use_typed) expected_replies.push_back(typed_want);
        else if (has_reply) expected_replies.push_back(predicted);
        if (counted) items_sent++;
        steady_tail = (items_sent >= TOTAL_ITEMS - TAIL_ITEMS);
        if (!steady_tail) begin
            if (tx_calm > 0) begin
                tx_calm--;
            end else if ($urandom_range(0, 9) == 0) begin
                tx_calm = $urandom_range(20, 80);
            end else if ($urandom_range(0, 4) == 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge aclk);
            end
        end
    endtask

    task automatic compare_reply(input result_t want);
        if (m_status !== want.status || m_error_code !== want.error_code ||
            m_payload_length !== want.payload_length ||
            m_internal_temp !== want.internal_temp ||
            m_external_temp_one !== want.external_temp_one ||
            m_external_temp_two !== want.external_temp_two) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t: reply mismatch: expected st %0d code %02h len %02h t %0d %0d %0d",
                         $realtime, want.status, want.error_code, want.payload_length,
                         $signed(want.internal_temp), $signed(want.external_temp_one),
                         $signed(want.external_temp_two));
                $display("%0t:                 got      st %0d code %02h len %02h t %0d %0d %0d",
                         $realtime, m_status, m_error_code, m_payload_length,
                         m_internal_temp, m_external_temp_one, m_external_temp_two);
            end
        end
    endtask

    // result side: compare against the oldest outstanding reply
    always @(posedge aclk) begin
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (expected_replies.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: reply word with nothing outstanding", $realtime);
                end
            end else begin
                compare_reply(expected_replies.pop_front());
            end
        end
    end

    // watchdog on cycles with no handshake on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready === 1'b1) || (m_valid === 1'b1 && m_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $realtime, stall_cycles);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // receiver: random stall bursts, calm stretches, one long hold-off
    initial begin
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (!long_hold_done && items_sent >= HOLD_AT) begin
                long_hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                m_ready <= 1'b1;
            end else if (steady_tail || rx_calm > 0) begin
                if (rx_calm > 0) rx_calm--;
                m_ready <= 1'b1;
            end else if ($urandom_range(0, 9) == 0) begin
                rx_calm = $urandom_range(20, 80);
                m_ready <= 1'b1;
            end else if ($urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // sender: reset, directed rows, then random frames
    initial begin : stimulus
        int          n;
        int          pick;
        bit          paused_once;
        logic        err_kind;
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [15:0] flip;
        reply_row_t  row;

        aresetn       <= 1'b0;
        s_valid       <= 1'b0;
        s_rx_byte     <= 8'h00;
        s_frame_start <= 1'b0;
        frame_pos     = 4'd0;
        frame_open    = 1'b0;
        crc_acc       = CRC_INIT;
        err_reply     = 1'b0;
        held_len_code = 8'h00;
        held_crc_lo   = 8'h00;
        foreach (held_temp[i]) held_temp[i] = 16'h0000;
        items_sent    = 0;
        mismatches    = 0;
        stall_cycles  = 0;
        tx_calm       = 0;
        rx_calm       = 0;
        steady_tail   = 1'b0;
        long_hold_done = 1'b0;
        paused_once   = 1'b0;

        // stray word with no open frame, then a data frame cut off by a restart
        directed_rows[0] = '{1'b1, 1'b0, NODE_ADDR, 8'h00, 8'h00, 8'h00, 16'h0000,
                             16'h0000, 16'h0000, 16'h0000, 4'd0, 1'b0, '0};
        directed_rows[1] = '{1'b0, 1'b0, NODE_ADDR, CMD_READ_TEMPS, 8'h06, 8'h00,
                             16'h0000, 16'h0000, 16'h0000, 16'h0000, 4'd2, 1'b0, '0};
        // data replies at the temperature extremes, good and bad check word
        directed_rows[2] = '{1'b0, 1'b0, 8'h00, 8'hFF, 8'hFF, 8'h00, TEMP_ABSENT,
                             TEMP_MAX, 16'hFFFF, 16'h0000, 4'd0, 1'b1,
                             '{STATUS_DATA_OK, 8'h00, 8'hFF, TEMP_ABSENT, TEMP_MAX,
                               16'hFFFF}};
        directed_rows[3] = '{1'b0, 1'b0, 8'hFF, 8'h01, 8'h00, 8'h00, 16'h0000,
                             TEMP_ABSENT, 16'h0001, 16'hFFFF, 4'd0, 1'b1,
                             '{STATUS_DATA_BAD, 8'h00, 8'h00, 16'h0000, TEMP_ABSENT,
                               16'h0001}};
        // error replies with extreme codes
        directed_rows[4] = '{1'b0, 1'b1, NODE_ADDR, 8'h00, 8'hFF, 8'hFF, 16'h0000,
                             16'h0000, 16'h0000, 16'h0000, 4'd0, 1'b1,
                             '{STATUS_ERR_OK, 8'hFF, 8'h00, 16'h0000, 16'h0000,
                               16'h0000}};
        directed_rows[5] = '{1'b0, 1'b1, 8'hFF, 8'h00, 8'h00, 8'h00, 16'h0000,
                             16'h0000, 16'h0000, 16'h0001, 4'd0, 1'b1,
                             '{STATUS_ERR_BAD, 8'h00, 8'h00, 16'h0000, 16'h0000,
                               16'h0000}};
        // word after a closed frame is dropped
        directed_rows[6] = '{1'b1, 1'b0, 8'h55, 8'h00, 8'h00, 8'h00, 16'h0000,
                             16'h0000, 16'h0000, 16'h0000, 4'd0, 1'b0, '0};

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[r]) begin
            row = directed_rows[r];
            if (row.stray) begin
                send_byte(row.b0, 1'b0, 1'b0, 1'b0, '0);
            end else begin
                build_reply(row.err_kind, row.b0, row.b1, row.b2, row.b3, row.t0, row.t1,
                            row.t2, row.crc_flip);
                n = (row.cut != 0) ? int'(row.cut) : reply_bytes.size();
                for (int i = 0; i < n; i++) begin
                    send_byte(reply_bytes[i], i == 0, 1'b1, row.typed && i == n - 1,
                              row.want);
                end
            end
        end

        while (items_sent < TOTAL_ITEMS) begin
            if (!paused_once && items_sent >= PAUSE_AT) begin
                paused_once = 1'b1;
                s_valid <= 1'b0;
                do @(posedge aclk); while (expected_replies.size() != 0);
            end
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                // stray words; they continue a frame if one was left open
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0, 1'b0, 1'b0, '0);
            end else begin
                err_kind = ($urandom_range(0, 2) == 0);
                b0 = $urandom_range(0, 1) ? NODE_ADDR : 8'($urandom);
                b1 = $urandom_range(0, 1) ? CMD_READ_TEMPS : 8'($urandom_range(1, 255));
                case ($urandom_range(0, 5))
                    0: flip = 16'(1 << $urandom_range(0, 15));
                    1: flip = 16'($urandom_range(1, 65535));
                    default: flip = 16'h0000;
                endcase
                build_reply(err_kind, b0, b1, 8'($urandom), 8'($urandom), pick_temp(),
                            pick_temp(), pick_temp(), flip);
                // a cut-off frame is restarted by the next frame
                n = (pick < 20) ? $urandom_range(1, reply_bytes.size() - 1)
                                : reply_bytes.size();
                for (int i = 0; i < n; i++) begin
                    send_byte(reply_bytes[i], i == 0, 1'b1, 1'b0, '0);
                end
            end
        end

        s_valid <= 1'b0;
        while (expected_replies.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
